// ===== sv/kwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes for the k-way sorted merge engine.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned IdxW = 3;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  // One command handed from the front end to the back end.
  typedef struct packed {
    op_t                   op;
    logic [IdxW-1:0]       list;
    logic [ValW-1:0]       value;
  } cmd_t;

  // One result handed from the back end to the output queue.
  typedef struct packed {
    status_t               status;
    logic [ValW-1:0]       value;
    logic [IdxW-1:0]       list;
  } res_t;

endpackage : kwm_pkg
`default_nettype wire

// ===== sv/k_way_sorted_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// K-way merge engine with one FIFO per sorted list.
// ----------------------------------------------------------------------------
// Input queue: drive in_op/in_list_index/in_value with push while full is low.
// An append stores the value on the tail of its list (status 0) or drops it
// when the list is full or the index is out of range (status 3). A pop
// returns the smallest head, lowest list first on ties (status 1), or
// status 2 when every list is empty.
// Result queue: the oldest result sits on out_* while empty is low; pop takes
// it. A two-entry command queue decouples input from the back end, and the
// back end holds at most one result, so a stalled receiver backs up into full.
// A pop scans the head registers one list per cycle, then reads the element
// memory and loads the next head; its result is registered at the end of the
// scan. Every command passes through the command queue and the back end's
// result register, and is taken only while the back end is idle.
// Reset empties all lists and queues; memory contents need no clearing.
// ----------------------------------------------------------------------------
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int unsigned NUM_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_op,
  input  wire logic [IdxW-1:0]   in_list_index,
  input  wire logic [ValW-1:0]   in_value,
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             out_status,
  output logic [ValW-1:0]        out_value,
  output logic [IdxW-1:0]        out_list
);

  cmd_t in_cmd, q_head;
  logic q_empty, q_take;
  res_t res;
  logic res_valid;

  assign in_cmd.op    = op_t'(in_op);
  assign in_cmd.list  = in_list_index;
  assign in_cmd.value = in_value;

  kwm_cmd_fifo u_q (
    .clk, .rst_n,
    .push, .push_data(in_cmd), .full,
    .pop(q_take), .head(q_head), .empty(q_empty)
  );

  // The back end takes the head command when idle with its result slot free.
  kwm_engine #(.NUM_LISTS(NUM_LISTS), .LIST_DEPTH(LIST_DEPTH)) u_eng (
    .clk, .rst_n,
    .cmd(q_head), .cmd_valid(!q_empty), .cmd_take(q_take),
    .res, .res_valid, .res_ready(pop)
  );

  assign empty      = !res_valid;
  assign out_status = res.status;
  assign out_value  = res.value;
  assign out_list   = res.list;

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_EMPTY) |-> (out_value == '0 && out_list == '0))
    else $error("empty-pop result carries data");
  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !q_empty)
    else $error("command taken from an empty queue");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) && $stable(out_value) &&
                          $stable(out_list)))
    else $error("waiting result changed or vanished");

endmodule : k_way_sorted_merge
`default_nettype wire

// ===== sv/kwm_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_cmd_fifo
// Two-entry command queue between the input front end and the merge back end.
// ----------------------------------------------------------------------------
module kwm_cmd_fifo
  import kwm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count.
  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queued commands.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule : kwm_cmd_fifo
`default_nettype wire

// ===== sv/kwm_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_engine
// Back end: per-list FIFOs in one memory, head registers, and a registered
// minimum search over the heads.
// ----------------------------------------------------------------------------
module kwm_engine
  import kwm_pkg::*;
#(
  parameter int unsigned NUM_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cmd_t      cmd,
  input  wire logic cmd_valid,
  output logic      cmd_take,
  output res_t      res,
  output logic      res_valid,
  input  wire logic res_ready
);

  localparam int unsigned LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = LW + PW;
  // Each list owns a power-of-two slice so the address is {list, slot}.
  localparam int unsigned MEM_DEPTH = NUM_LISTS * (1 << PW);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Element memory: heads live in registers, the rest of each list here.
  logic [ValW-1:0] mem [MEM_DEPTH];
  logic [ValW-1:0] rdata_r;

  logic [PW-1:0]   rp_r  [NUM_LISTS];
  logic [PW-1:0]   wp_r  [NUM_LISTS];
  logic [CW-1:0]   cnt_r [NUM_LISTS];
  logic [ValW-1:0] head_r [NUM_LISTS];

  // Result register.
  res_t            res_r;
  logic            res_valid_r, res_valid_nxt;

  // Scan state.
  logic [LW-1:0]   scan_r;
  logic            found_r;
  logic [LW-1:0]   best_r;
  logic [ValW-1:0] best_val_r;
  logic [LW-1:0]   sel_r;

  logic            is_app, app_ok, idx_ok, app_take;
  logic [LW-1:0]   app_list;
  logic [AW-1:0]   wr_addr;
  logic            head_direct;
  logic            scan_last;

  assign res       = res_r;
  assign res_valid = res_valid_r;

  assign is_app   = (cmd.op == OP_APPEND);
  assign idx_ok   = ({{(32-IdxW){1'b0}}, cmd.list} < NUM_LISTS);
  assign app_list = LW'(cmd.list);
  assign app_ok   = idx_ok && ({{(32-CW){1'b0}}, cnt_r[app_list]} < LIST_DEPTH);
  assign wr_addr  = {app_list, wp_r[app_list]};
  // Empty list: value goes straight to its head register.
  assign head_direct = (cnt_r[app_list] == '0);
  assign scan_last   = ({{(32-LW){1'b0}}, scan_r} == NUM_LISTS - 1);

  // Take any command while idle with the result slot free.
  assign cmd_take = (state_r == S_IDLE) && cmd_valid && (!res_valid_r || res_ready);
  assign app_take = cmd_take && is_app;

  // Sequence a pop: scan heads one per cycle, then refill the head.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd_take && !is_app) state_nxt = S_SCAN;
      S_SCAN:  if (scan_last) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic pop_done;
  logic found_fin;
  logic [LW-1:0]   best_fin;
  logic [ValW-1:0] best_val_fin;
  logic cand;

  assign cand = (cnt_r[scan_r] != '0) &&
                (!found_r || ($signed(head_r[scan_r]) < $signed(best_val_r)));
  assign found_fin    = found_r || cand;
  assign best_fin     = cand ? scan_r : best_r;
  assign best_val_fin = cand ? head_r[scan_r] : best_val_r;
  assign pop_done     = (state_r == S_SCAN) && scan_last;

  // Raise on a new result, drop when the receiver takes it.
  always_comb begin
    priority if (app_take || pop_done) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      // Append transaction.
      if (app_take) begin
        res_r.list  <= cmd.list;
        res_r.value <= '0;
        if (app_ok) begin
          res_r.status <= ST_APPENDED;
          cnt_r[app_list] <= cnt_r[app_list] + 1'b1;
          if (!head_direct) begin
            wp_r[app_list] <= (wp_r[app_list] == PW'(LIST_DEPTH - 1)) ? '0
                              : wp_r[app_list] + 1'b1;
          end
        end else begin
          res_r.status <= ST_FULL;
        end
      end
      if (state_r == S_IDLE && state_nxt == S_SCAN) begin
        scan_r  <= '0;
        found_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        found_r    <= found_fin;
        best_r     <= best_fin;
        best_val_r <= best_val_fin;
        scan_r     <= scan_r + 1'b1;
      end
      // Report the pop and drop the head.
      if (pop_done) begin
        sel_r <= best_fin;
        if (found_fin) begin
          res_r.status <= ST_POPPED;
          res_r.value  <= best_val_fin;
          res_r.list   <= IdxW'(best_fin);
          cnt_r[best_fin] <= cnt_r[best_fin] - 1'b1;
        end else begin
          res_r.status <= ST_EMPTY;
          res_r.value  <= '0;
          res_r.list   <= '0;
        end
      end
      // Advance the read pointer once the next head is loaded.
      if (state_r == S_LOAD && cnt_r[sel_r] != '0 && found_r) begin
        rp_r[sel_r] <= (rp_r[sel_r] == PW'(LIST_DEPTH - 1)) ? '0 : rp_r[sel_r] + 1'b1;
      end
    end
  end

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (app_take && app_ok && !head_direct) begin
      mem[wr_addr] <= cmd.value;
    end
    rdata_r <= mem[{sel_r, rp_r[sel_r]}];
  end

  // Head registers.
  always_ff @(posedge clk) begin
    if (app_take && app_ok && head_direct) begin
      head_r[app_list] <= cmd.value;
    end
    if (state_r == S_LOAD && found_r) begin
      head_r[sel_r] <= rdata_r;
    end
  end

endmodule : kwm_engine
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the k-way sorted merge engine.
// ----------------------------------------------------------------------------
// Append and pop commands are queued, then fed to the input queue with random
// gaps. A behavioral model of the eight list FIFOs computes the expected
// result of each accepted command. A monitor pops results under random stalls
// and compares status, value and list with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top
  import kwm_pkg::*;
();

  localparam int Lists     = 8;
  localparam int Depth     = 16;
  localparam int WatchMax  = 20000;

  typedef struct {
    op_t         op;
    logic [2:0]  list;
    logic [31:0] value;
  } merge_cmd_t;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [2:0]  list;
  } merge_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        in_op = 1'b0;
  logic [2:0]  in_list_index = '0;
  logic [31:0] in_value = '0;
  logic        pop = 1'b0;
  wire         full;
  wire         empty;
  wire  [1:0]  out_status;
  wire  [31:0] out_value;
  wire  [2:0]  out_list;

  merge_cmd_t  pending_cmds[$];
  merge_res_t  expected_results[$];
  logic [31:0] list_fifo[Lists][$];
  int          errors = 0;
  int          n_pushed = 0;
  int          n_popped = 0;
  int          n_valid_pops = 0;
  int          n_drops = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          drain_hold = 1'b0;

  k_way_sorted_merge dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_op(in_op), .in_list_index(in_list_index), .in_value(in_value),
    .empty(empty), .pop(pop), .out_status(out_status),
    .out_value(out_value), .out_list(out_list)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one command to the list model and record its result.
  function automatic void predict_merge(merge_cmd_t c);
    merge_res_t r;
    int         best;
    best = -1;
    r.value = '0;
    if (c.op == OP_APPEND) begin
      r.list = c.list;
      if (list_fifo[c.list].size() >= Depth) begin
        r.status = ST_FULL;
      end else begin
        list_fifo[c.list].insert(list_fifo[c.list].size(), c.value);
        r.status = ST_APPENDED;
      end
    end else begin
      // lowest index wins ties: strict less keeps the earlier list
      for (int i = 0; i < Lists; i++) begin
        if (list_fifo[i].size() != 0) begin
          if (best < 0 || $signed(list_fifo[i][0]) < $signed(list_fifo[best][0]))
            best = i;
        end
      end
      if (best < 0) begin
        r.status = ST_EMPTY;
        r.list = '0;
      end else begin
        r.status = ST_POPPED;
        r.value = list_fifo[best].pop_front();
        r.list = best[2:0];
      end
    end
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void add_cmd(op_t op, int list, logic [31:0] value);
    merge_cmd_t c;
    c.op = op;
    c.list = list[2:0];
    c.value = value;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Driver: hold the command until it is taken, then advance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        predict_merge(pending_cmds.pop_front());
        n_pushed++;
      end
      if (push && full) begin
        // keep presenting the same command
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (drain_hold || pending_cmds.size() == 0) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_op <= pending_cmds[0].op;
        in_list_index <= pending_cmds[0].list;
        in_value <= pending_cmds[0].value;
        send_gap <= pick_gap();
      end
    end
  end

  // Monitor: take results under random stalls and compare.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        n_popped++;
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding: status %0d", out_status);
          errors++;
        end else begin
          merge_res_t e;
          e = expected_results.pop_front();
          if (out_status != e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            errors++;
          end
          if (out_value != e.value) begin
            $error("out_value expected %0d actual %0d",
                   $signed(e.value), $signed(out_value));
            errors++;
          end
          if (out_list != e.list) begin
            $error("out_list expected %0d actual %0d", e.list, out_list);
            errors++;
          end
          if (e.status == ST_POPPED) n_valid_pops++;
          if (e.status == ST_FULL) n_drops++;
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else if (pop && !empty) begin
        recv_gap <= pick_gap();
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchMax) begin
      $display("watchdog: no transaction for %0d cycles", WatchMax);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Append random values to random lists, mixed with pops, then add more pops.
  task automatic add_sorted_batch();
    int          n;
    logic [31:0] base;
    n = $urandom_range(4, 30);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom;
        add_cmd(OP_APPEND, $urandom_range(0, Lists - 1), base);
      end else begin
        add_cmd(OP_POP, $urandom_range(0, 7), $urandom);
      end
    end
    for (int k = 0; k < n / 2 + $urandom_range(0, 6); k++)
      add_cmd(OP_POP, $urandom_range(0, 7), $urandom);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    // Directed: empty pop, extremes, ties, overflow of one list.
    add_cmd(OP_POP, 5, 32'hdead_beef);
    add_cmd(OP_APPEND, 0, 32'h7fff_ffff);
    add_cmd(OP_APPEND, 7, 32'h8000_0000);
    add_cmd(OP_APPEND, 3, 32'h0000_0005);
    add_cmd(OP_APPEND, 5, 32'h0000_0005);
    add_cmd(OP_APPEND, 1, 32'hffff_ffff);
    for (int k = 0; k < 6; k++) add_cmd(OP_POP, 7 - k, 32'hffff_ffff);
    for (int k = 0; k < Depth + 1; k++) add_cmd(OP_APPEND, 2, k);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    // Sender holds off while the pops below are queued, then is released.
    drain_hold = 1'b1;
    for (int k = 0; k < Depth; k++) add_cmd(OP_POP, 0, 0);
    add_cmd(OP_POP, 0, 0);
    repeat (20) @(posedge clk);
    drain_hold = 1'b0;
    wait_drained();
    while (n_pushed < 700) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 0; k < 10; k++)
          add_cmd(op_t'($urandom_range(0, 1)), $urandom_range(0, 7), rand_value());
      end else begin
        add_sorted_batch();
      end
      wait_drained();
    end
    repeat (50) @(posedge clk);
    $display("covered %0d commands: %0d values popped, %0d appends dropped",
             n_pushed, n_valid_pops, n_drops);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kwm_pkg.sv
sv/kwm_cmd_fifo.sv
sv/kwm_engine.sv
sv/k_way_sorted_merge.sv
tb/tb_top.sv
